[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/ebac_pkg.sv]
// ----------------------------------------------------------------------------
// ebac_pkg
// Types, codes and encode helper for the enhanced bus adapter command parser.
// ----------------------------------------------------------------------------
package ebac_pkg;

   // item operations
   localparam logic [1:0] OP_BYTE     = 2'd0;
   localparam logic [1:0] OP_ARB_DONE = 2'd1;
   localparam logic [1:0] OP_PUSH     = 2'd2;

   // result actions
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_BUS   = 2'd1;
   localparam logic [1:0] ACT_REPLY = 2'd2;
   localparam logic [1:0] ACT_CLOSE = 2'd3;

   // protocol commands and replies
   localparam logic [3:0] OPC_INIT       = 4'd0;
   localparam logic [3:0] OPC_SEND       = 4'd1;
   localparam logic [3:0] OPC_START      = 4'd2;
   localparam logic [3:0] OPC_INFO       = 4'd3;
   localparam logic [3:0] RES_RESETTED   = 4'd0;
   localparam logic [3:0] RES_ERROR_HOST = 4'hC;
   localparam logic [7:0] FRAMING_ERR    = 8'd0;
   localparam logic [7:0] SYN_BYTE       = 8'hAA;

   localparam logic [1:0] SIG_FIRST  = 2'b11;
   localparam logic [1:0] SIG_SECOND = 2'b10;

   localparam logic CLOSE_FIRST  = 1'b0;
   localparam logic CLOSE_SECOND = 1'b1;

   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] client_id;
      logic [7:0] rx_byte;
      logic [3:0] reply_code;
      logic [7:0] reply_data;
      logic       tx_room;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] client;
      logic [7:0] address;
   } owner_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] target_client;
      logic [7:0] bus_byte;
      logic [7:0] reply_first;
      logic [7:0] reply_second;
      logic       close_reason;
      owner_type  arb;
   } result_type;

   // per-client state updates requested by the decoder
   typedef struct packed {
      logic await_wr;
      logic await_val;
      logic held_wr;
   } update_type;

   function automatic logic [15:0] encode_reply(input logic [3:0] code,
                                                input logic [7:0] data);
      encode_reply = {SIG_FIRST, code, data[7:6], SIG_SECOND, data[5:0]};
   endfunction

endpackage

[sv/ebac_held_ram.sv]
// ----------------------------------------------------------------------------
// ebac_held_ram
// Per-client store of the pending first command byte, registered read with
// a bypass for a write landing on the same edge as the read.
// ----------------------------------------------------------------------------
module ebac_held_ram #(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [7:0]       wr_data,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_q_ff;
   logic       byp_ff;
   logic [7:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_idx];
         byp_ff      <= wr_en && (wr_idx == rd_idx);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

[sv/ebac_decode.sv]
// ----------------------------------------------------------------------------
// ebac_decode
// Byte classification, command decode, arbitration ownership and reply
// encoding for one item.
// ----------------------------------------------------------------------------
module ebac_decode
   import ebac_pkg::*;
(
   input  item_type   item,
   input  logic       in_range,
   input  logic       awaiting,
   input  logic [7:0] first_byte,
   input  owner_type  owner,
   output result_type res,
   output owner_type  owner_next,
   output update_type upd
);

   logic [3:0] code;
   logic [7:0] data;
   logic       act_bus;
   logic       act_reply;
   logic       act_close;
   logic       close_why;
   logic [7:0] bus_val;
   logic [3:0] rep_code;
   logic [7:0] rep_data;
   logic [15:0] rep_enc;

   assign code = first_byte[5:2];
   assign data = {first_byte[1:0], item.rx_byte[5:0]};

   always_comb begin
      act_bus    = 1'b0;
      act_reply  = 1'b0;
      act_close  = 1'b0;
      close_why  = CLOSE_FIRST;
      bus_val    = item.rx_byte;
      rep_code   = item.reply_code;
      rep_data   = item.reply_data;
      owner_next = owner;
      upd        = '0;
      if (item.operation == OP_ARB_DONE) begin
         owner_next = '0;
      end else if (in_range && item.operation == OP_BYTE) begin
         if (!awaiting) begin
            if (!item.rx_byte[7]) begin
               act_bus = 1'b1;
            end else if (!item.rx_byte[6]) begin
               act_close = 1'b1;
            end else begin
               upd.held_wr   = 1'b1;
               upd.await_wr  = 1'b1;
               upd.await_val = 1'b1;
            end
         end else begin
            upd.await_wr  = 1'b1;
            upd.await_val = 1'b0;
            if (item.rx_byte[7:6] != SIG_SECOND) begin
               act_close = 1'b1;
               close_why = CLOSE_SECOND;
            end else begin
               case (code)
                  OPC_INIT: begin
                     act_reply = 1'b1;
                     rep_code  = RES_RESETTED;
                     rep_data  = 8'd0;
                  end
                  OPC_SEND: begin
                     act_bus = 1'b1;
                     bus_val = data;
                  end
                  OPC_START: begin
                     if (data == SYN_BYTE) begin
                        owner_next = '0;
                     end else if (owner.valid && owner.client != item.client_id) begin
                        act_reply = 1'b1;
                        rep_code  = RES_ERROR_HOST;
                        rep_data  = FRAMING_ERR;
                     end else begin
                        owner_next.valid   = 1'b1;
                        owner_next.client  = item.client_id;
                        owner_next.address = data;
                     end
                  end
                  default: begin
                     // info and unknown commands: no effect
                  end
               endcase
            end
         end
      end else if (in_range && item.operation == OP_PUSH) begin
         act_reply = item.tx_room;
      end
   end

   assign rep_enc = encode_reply(rep_code, rep_data);

   always_comb begin
      res              = '0;
      res.arb          = owner_next;
      if (act_bus) begin
         res.action   = ACT_BUS;
         res.bus_byte = bus_val;
      end else if (act_reply) begin
         res.action       = ACT_REPLY;
         res.reply_first  = rep_enc[15:8];
         res.reply_second = rep_enc[7:0];
      end else if (act_close) begin
         res.action       = ACT_CLOSE;
         res.close_reason = close_why;
      end
      if (act_bus || act_reply || act_close) begin
         res.target_client = item.client_id;
      end
   end

endmodule

[sv/enhanced_bus_adapter_command_parser.sv]
// ----------------------------------------------------------------------------
// enhanced_bus_adapter_command_parser
// Parses client byte streams of the enhanced bus adapter protocol.
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one item per beat: a client byte, an arbitration-done
//   notice or a reply to push. rsp_* returns exactly one result beat per
//   item: the action (bus byte, two-byte reply, close) plus the current
//   arbitration owner after the item.
//   an accepted item is registered in the decode stage, and its result in
//   the result register that drives rsp_*.
//   throughput: one item per cycle while the result is not stalled. The
//   pending first byte of each client sits in a synchronous ram; a write
//   and a read of the same client on one edge use a bypass register.
//   reset clears the per-client pending flags, the owner and both pipeline
//   valids; no clearing pass is needed.
//   a valid result holds while rsp_stall is high; one more item is held
//   in the decode stage, after which req_stall rises until the result moves.
// ----------------------------------------------------------------------------
module enhanced_bus_adapter_command_parser
   import ebac_pkg::*;
#(
   parameter int CLIENTS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_client_id,
   input  logic [7:0] req_rx_byte,
   input  logic [3:0] req_reply_code,
   input  logic [7:0] req_reply_data,
   input  logic       req_tx_room,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_action,
   output logic [2:0] rsp_target_client,
   output logic [7:0] rsp_bus_byte,
   output logic [7:0] rsp_reply_first,
   output logic [7:0] rsp_reply_second,
   output logic       rsp_close_reason,
   output logic       rsp_arb_requested,
   output logic [2:0] rsp_arb_client,
   output logic [7:0] rsp_arb_address
);

`include "assert_macros.svh"

   localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

   logic               req_accept;
   logic               s1_go;
   logic               s1_fire;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   item_type           s1_ff;
   logic [IDX_W-1:0]   s1_idx;
   logic               in_range;
   logic               awaiting;
   logic [7:0]         first_byte;
   logic [CLIENTS-1:0] await_ff;
   logic [CLIENTS-1:0] await_in;
   owner_type          owner_ff;
   owner_type          owner_next;
   result_type         res;
   update_type         upd;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_type         rsp_ff;

   assign s1_go      = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && s1_go;
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   assign s1_idx   = IDX_W'(s1_ff.client_id);
   assign in_range = ({29'd0, s1_ff.client_id} < 32'(CLIENTS));
   assign awaiting = in_range && await_ff[s1_idx];

   ebac_held_ram #(
      .DEPTH (CLIENTS),
      .IDX_W (IDX_W)
   ) u_held_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_idx  (IDX_W'(req_client_id)),
      .wr_en   (s1_fire && upd.held_wr),
      .wr_idx  (s1_idx),
      .wr_data (s1_ff.rx_byte),
      .rd_data (first_byte)
   );

   ebac_decode u_decode (
      .item       (s1_ff),
      .in_range   (in_range),
      .awaiting   (awaiting),
      .first_byte (first_byte),
      .owner      (owner_ff),
      .res        (res),
      .owner_next (owner_next),
      .upd        (upd)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = s1_valid_ff;
      end
      await_in = await_ff;
      if (s1_fire && upd.await_wr) begin
         await_in[s1_idx] = upd.await_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         await_ff     <= '0;
         owner_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         await_ff     <= await_in;
         if (s1_fire) begin
            owner_ff <= owner_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff.operation  <= req_operation;
         s1_ff.client_id  <= req_client_id;
         s1_ff.rx_byte    <= req_rx_byte;
         s1_ff.reply_code <= req_reply_code;
         s1_ff.reply_data <= req_reply_data;
         s1_ff.tx_room    <= req_tx_room;
      end
      if (s1_fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_target_client = rsp_ff.target_client;
   assign rsp_bus_byte      = rsp_ff.bus_byte;
   assign rsp_reply_first   = rsp_ff.reply_first;
   assign rsp_reply_second  = rsp_ff.reply_second;
   assign rsp_close_reason  = rsp_ff.close_reason;
   assign rsp_arb_requested = rsp_ff.arb.valid;
   assign rsp_arb_client    = rsp_ff.arb.client;
   assign rsp_arb_address   = rsp_ff.arb.address;

   `ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, s1_valid_ff)
   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, s1_valid_ff)
   `ASSERT_NEXT(a_fire_fills_output, clock, reset, s1_fire, rsp_valid_ff)
   `ASSERT_SAME(a_no_owner_is_zero, clock, reset, rsp_valid && !rsp_arb_requested, rsp_arb_client == 3'd0 && rsp_arb_address == 8'd0)
   `ASSERT_SAME(a_idle_result_clean, clock, reset, rsp_valid && rsp_action == ACT_NONE, rsp_target_client == 3'd0 && rsp_reply_first == 8'd0 && rsp_bus_byte == 8'd0)

endmodule

[dv/tb_enhanced_bus_adapter_command_parser.sv]
// ----------------------------------------------------------------------------
// tb_enhanced_bus_adapter_command_parser
// Drives client bytes, arbitration-done notices and pushed replies into the
// command parser and compares every result beat against a parser model kept
// in the bench: per-client pending first bytes plus the arbitration owner.
// ----------------------------------------------------------------------------
module tb_enhanced_bus_adapter_command_parser
   import ebac_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         NUM_CLIENTS = 8;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         DRAIN_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = '0;
   logic [2:0] req_client_id = '0;
   logic [7:0] req_rx_byte = '0;
   logic [3:0] req_reply_code = '0;
   logic [7:0] req_reply_data = '0;
   logic       req_tx_room = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_action;
   logic [2:0] rsp_target_client;
   logic [7:0] rsp_bus_byte;
   logic [7:0] rsp_reply_first;
   logic [7:0] rsp_reply_second;
   logic       rsp_close_reason;
   logic       rsp_arb_requested;
   logic [2:0] rsp_arb_client;
   logic [7:0] rsp_arb_address;

   // parser model state
   logic       pend_flag [NUM_CLIENTS] = '{default: 1'b0};
   logic [7:0] pend_first [NUM_CLIENTS] = '{default: 8'h00};
   owner_type  arb_owner = '0;

   result_type parsed_results [$];
   int         fail_count = 0;
   int         rsp_count = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         hold_left = 0;

   enhanced_bus_adapter_command_parser #(
      .CLIENTS(NUM_CLIENTS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_client_id     (req_client_id),
      .req_rx_byte       (req_rx_byte),
      .req_reply_code    (req_reply_code),
      .req_reply_data    (req_reply_data),
      .req_tx_room       (req_tx_room),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_target_client (rsp_target_client),
      .rsp_bus_byte      (rsp_bus_byte),
      .rsp_reply_first   (rsp_reply_first),
      .rsp_reply_second  (rsp_reply_second),
      .rsp_close_reason  (rsp_close_reason),
      .rsp_arb_requested (rsp_arb_requested),
      .rsp_arb_client    (rsp_arb_client),
      .rsp_arb_address   (rsp_arb_address)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_enhanced_bus_adapter_command_parser failed");
      $finish;
   end

   function automatic result_type reply_of(input logic [3:0] code, input logic [7:0] data);
      result_type r;
      r = '0;
      r.action = ACT_REPLY;
      r.reply_first = {SIG_FIRST, code, data[7:6]};
      r.reply_second = {SIG_SECOND, data[5:0]};
      return r;
   endfunction

   function automatic result_type run_command(input logic [2:0] cl, input logic [3:0] code,
                                              input logic [7:0] data);
      result_type r;
      r = '0;
      case (code)
         OPC_INIT: r = reply_of(RES_RESETTED, 8'h00);
         OPC_SEND: begin
            r.action = ACT_BUS;
            r.bus_byte = data;
         end
         OPC_START: begin
            if (data == SYN_BYTE) begin
               arb_owner = '0;
            end else if (arb_owner.valid && arb_owner.client != cl) begin
               r = reply_of(RES_ERROR_HOST, FRAMING_ERR);
            end else begin
               arb_owner.valid = 1'b1;
               arb_owner.client = cl;
               arb_owner.address = data;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic result_type parse_item(input item_type it);
      result_type r;
      logic [2:0] cl;
      r = '0;
      cl = it.client_id;
      case (it.operation)
         OP_ARB_DONE: arb_owner = '0;
         OP_BYTE: begin
            if (!pend_flag[cl]) begin
               if (it.rx_byte[7] == 1'b0) begin
                  r.action = ACT_BUS;
                  r.bus_byte = it.rx_byte;
               end else if (it.rx_byte[7:6] == SIG_SECOND) begin
                  r.action = ACT_CLOSE;
                  r.close_reason = CLOSE_FIRST;
               end else begin
                  pend_first[cl] = it.rx_byte;
                  pend_flag[cl] = 1'b1;
               end
            end else begin
               pend_flag[cl] = 1'b0;
               if (it.rx_byte[7:6] != SIG_SECOND) begin
                  r.action = ACT_CLOSE;
                  r.close_reason = CLOSE_SECOND;
               end else begin
                  r = run_command(cl, pend_first[cl][5:2],
                                  {pend_first[cl][1:0], it.rx_byte[5:0]});
               end
            end
         end
         OP_PUSH: begin
            if (it.tx_room) r = reply_of(it.reply_code, it.reply_data);
         end
         default: ;
      endcase
      if (r.action != ACT_NONE) r.target_client = cl;
      r.arb = arb_owner;
      return r;
   endfunction

   task automatic flag_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("error at result beat %0d: %s", rsp_count, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         flag_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parsed_results.size() == 0) begin
            flag_failure("result beat with nothing expected");
         end else begin
            want = parsed_results.pop_front();
            check_field("action", 8'(rsp_action), 8'(want.action));
            check_field("target_client", 8'(rsp_target_client), 8'(want.target_client));
            check_field("bus_byte", rsp_bus_byte, want.bus_byte);
            check_field("reply_first", rsp_reply_first, want.reply_first);
            check_field("reply_second", rsp_reply_second, want.reply_second);
            check_field("close_reason", 8'(rsp_close_reason), 8'(want.close_reason));
            check_field("arb_requested", 8'(rsp_arb_requested), 8'(want.arb.valid));
            check_field("arb_client", 8'(rsp_arb_client), 8'(want.arb.client));
            check_field("arb_address", rsp_arb_address, want.arb.address);
         end
         rsp_count++;
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_item(input item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= it.operation;
      req_client_id <= it.client_id;
      req_rx_byte <= it.rx_byte;
      req_reply_code <= it.reply_code;
      req_reply_data <= it.reply_data;
      req_tx_room <= it.tx_room;
      do @(posedge clock); while (req_stall);
      parsed_results.push_back(parse_item(it));
   endtask

   // fields the operation does not use carry random values
   function automatic item_type noise_item(input logic [1:0] op, input logic [2:0] cl);
      item_type it;
      it.operation = op;
      it.client_id = cl;
      it.rx_byte = 8'($urandom);
      it.reply_code = 4'($urandom);
      it.reply_data = 8'($urandom);
      it.tx_room = 1'($urandom);
      return it;
   endfunction

   task automatic send_byte(input logic [2:0] cl, input logic [7:0] b);
      item_type it;
      it = noise_item(OP_BYTE, cl);
      it.rx_byte = b;
      send_item(it);
   endtask

   task automatic send_cmd(input logic [2:0] cl, input logic [3:0] code, input logic [7:0] data);
      send_byte(cl, {SIG_FIRST, code, data[7:6]});
      send_byte(cl, {SIG_SECOND, data[5:0]});
   endtask

   task automatic send_push(input logic [2:0] cl, input logic [3:0] code, input logic [7:0] data,
                            input logic room);
      item_type it;
      it = noise_item(OP_PUSH, cl);
      it.reply_code = code;
      it.reply_data = data;
      it.tx_room = room;
      send_item(it);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (parsed_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (parsed_results.size() != 0) begin
         flag_failure($sformatf("%0d expected results never arrived", parsed_results.size()));
         parsed_results.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic test_directed();
      send_byte(3'd0, 8'h00);
      send_byte(3'd7, 8'h7F);
      send_byte(3'd1, 8'h80);
      send_byte(3'd2, 8'hBF);
      send_cmd(3'd0, OPC_INIT, 8'h00);
      send_cmd(3'd3, OPC_SEND, 8'hFF);
      send_cmd(3'd1, OPC_START, 8'h10);
      send_cmd(3'd2, OPC_START, 8'h20);      // owned by another client
      send_cmd(3'd1, OPC_START, 8'h55);      // owner restarts with a new address
      send_item(noise_item(OP_ARB_DONE, 3'd3));
      send_cmd(3'd4, OPC_START, 8'h01);
      send_cmd(3'd6, OPC_START, SYN_BYTE);   // syn clears the owner from anyone
      send_cmd(3'd4, OPC_INFO, 8'h3C);
      send_cmd(3'd5, 4'hF, 8'hC3);
      // pending first byte interleaved with another client, then a bad second byte
      send_byte(3'd6, 8'hFF);
      send_byte(3'd7, 8'h11);
      send_byte(3'd6, 8'h40);
      send_push(3'd7, 4'hF, 8'hFF, 1'b1);
      send_push(3'd4, 4'h5, 8'hA5, 1'b0);
      send_item(noise_item(OP_UNUSED, 3'd5));
      wait_drained();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int hold_pct);
      int sent;
      int pick;
      int sel;
      logic [2:0] cl;
      logic [3:0] code;
      logic [7:0] data;
      logic [1:0] top;
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         cl = 3'($urandom_range(NUM_CLIENTS - 1));
         if (pick < 55) begin
            sel = $urandom_range(99);
            if (sel < 15) code = OPC_INIT;
            else if (sel < 35) code = OPC_SEND;
            else if (sel < 75) code = OPC_START;
            else if (sel < 85) code = OPC_INFO;
            else code = 4'($urandom_range(15, 4));
            data = ($urandom_range(7) == 0) ? SYN_BYTE : 8'($urandom);
            send_cmd(cl, code, data);
            sent += 2;
         end else if (pick < 63) begin
            send_byte(cl, {1'b0, 7'($urandom)});
            sent++;
         end else if (pick < 68) begin
            send_byte(cl, {SIG_SECOND, 6'($urandom)});
            sent++;
         end else if (pick < 74) begin
            sel = $urandom_range(2);
            top = (sel == 2) ? SIG_FIRST : 2'(sel);
            send_byte(cl, {SIG_FIRST, 6'($urandom)});
            send_byte(cl, {top, 6'($urandom)});
            sent += 2;
         end else if (pick < 80) begin
            send_byte(cl, 8'($urandom));
            sent++;
         end else if (pick < 91) begin
            send_push(cl, 4'($urandom), 8'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 96) begin
            send_item(noise_item(OP_ARB_DONE, cl));
            sent++;
         end else begin
            send_item(noise_item(OP_UNUSED, cl));
            sent++;
         end
      end
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering beats until the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left <= 200;
      repeat (40) send_byte(3'($urandom_range(NUM_CLIENTS - 1)), {1'b0, 7'($urandom)});
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 24;
      stall_pct = 50;
      test_directed();
      test_random(500, 24, 50);
      test_random(500, 50, 24);
      test_backpressure();
      test_random(500, 0, 0);
      if (fail_count == 0) begin
         $display("tb_enhanced_bus_adapter_command_parser passed");
      end else begin
         $display("tb_enhanced_bus_adapter_command_parser failed");
      end
      $finish;
   end

endmodule
